@@ rtl/pts_pkg.sv @@
// Shared types and constants for the periodic task tick scheduler.
package pts_pkg;

    localparam int NUM_TASKS = 4;
    localparam int IDX_W     = 2;
    localparam int CNT_W     = 3;
    localparam int BUDGET_W  = 8;
    localparam int PERIOD_W  = 16;
    localparam int TICK_W    = 32;
    localparam int MISS_W    = 16;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_SELECT = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        CFG_POLICY  = 2'd0,
        CFG_COUNT   = 2'd1,
        CFG_BUDGETS = 2'd2,
        CFG_PERIODS = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        PASS_UPDATE = 1'b0,
        PASS_SELECT = 1'b1
    } t_pass;

    typedef enum logic {
        POLICY_RM  = 1'b0,
        POLICY_EDF = 1'b1
    } t_policy;

    typedef struct packed {
        logic [BUDGET_W-1:0] work;
        logic [PERIOD_W-1:0] phase;
        logic [TICK_W-1:0]   deadline;
    } t_task_st;

    typedef struct packed {
        t_pass            pass;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] en_count;
        t_policy          mode;
        logic             best_found;
    } t_unit_ctl;

endpackage

@@ rtl/pts_unit.sv @@
// Shared per-task unit: release and budget reload, or one step of the ready-task pick.
module pts_unit
    import pts_pkg::*;
(
    input  t_unit_ctl           i_ctl,
    input  t_task_st            i_task,
    input  logic [BUDGET_W-1:0] i_budget,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [TICK_W-1:0]   i_now,
    input  logic [TICK_W-1:0]   i_best_dl,
    output t_task_st            o_task,
    output logic                o_miss,
    output logic                o_take
);

    logic            enabled;
    logic [PERIOD_W:0] phase_inc;

    always_comb begin
        enabled   = ({1'b0, i_ctl.idx} < i_ctl.en_count) && (i_period != '0);
        phase_inc = {1'b0, i_task.phase} + (PERIOD_W+1)'(1);
        o_task    = i_task;
        o_miss    = 1'b0;
        o_take    = 1'b0;
        if (i_ctl.pass == PASS_UPDATE) begin
            if (!enabled) begin
                o_task.work  = '0;
                o_task.phase = '0;
            end else begin
                if (i_task.phase == '0) begin
                    o_miss          = (i_task.work != '0);
                    o_task.work     = i_budget;
                    o_task.deadline = i_now + {{(TICK_W-PERIOD_W){1'b0}}, i_period};
                end
                o_task.phase = (phase_inc >= {1'b0, i_period}) ? '0 : phase_inc[PERIOD_W-1:0];
            end
        end else if (i_task.work != '0) begin
            // Tasks are visited in index order, so the first hit wins under
            // rate monotonic, and a strict compare keeps ties on the lower index.
            if (i_ctl.mode == POLICY_RM) begin
                o_take = !i_ctl.best_found;
            end else begin
                o_take = !i_ctl.best_found || (i_task.deadline < i_best_dl);
            end
        end
    end

endmodule

@@ rtl/periodic_task_tick_scheduler_top.sv @@
// Top level of the periodic task tick scheduler: sequencer, task state and result register.
//
// Usage: each beat on the input channel (i_in_valid / o_in_ready, field i_restart)
// is one scheduler tick. A restart beat clears the tick count, miss total and all
// task state before the tick is handled. Each tick yields one result beat on the
// output channel (o_out_valid / i_out_ready).
// A tick walks the tasks one per cycle through a single shared unit, first to
// release tasks and reload budgets, then to pick the task that runs. The result
// is loaded into the output register in the finish step once that register is
// free; only then does the sequencer return to idle and take a new tick.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes a register
// at once and should be used only while no tick is in flight.
// Reset restores the default configuration and clears all task state.
// A stalled receiver holds the result in the output register; the next tick is
// still taken, and its result waits in the sequencer until the register frees.
module periodic_task_tick_scheduler_top
    import pts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [TICK_W-1:0]    o_tick_number,
    output logic [IDX_W-1:0]     o_running_task,
    output logic                 o_cpu_idle,
    output logic [NUM_TASKS-1:0] o_miss_mask,
    output logic [TICK_W-1:0]    o_chosen_deadline,
    output logic [MISS_W-1:0]    o_miss_total,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    t_state                        r_state;
    t_policy                       r_mode;
    logic [CNT_W-1:0]              r_count;
    logic [BUDGET_W*NUM_TASKS-1:0] r_budgets;
    logic [PERIOD_W*NUM_TASKS-1:0] r_periods;

    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_best;
    logic                 r_found;
    logic [TICK_W-1:0]    r_best_dl;
    logic [TICK_W-1:0]    r_tick;
    logic [MISS_W-1:0]    r_miss_cnt;
    logic [NUM_TASKS-1:0] r_miss_mask;
    t_task_st             r_task [NUM_TASKS];

    logic                 r_out_valid;
    logic [TICK_W-1:0]    r_o_tick;
    logic [IDX_W-1:0]     r_o_task;
    logic                 r_o_idle;
    logic [NUM_TASKS-1:0] r_o_mask;
    logic [TICK_W-1:0]    r_o_dl;
    logic [MISS_W-1:0]    r_o_miss;

    t_unit_ctl           unit_ctl;
    t_task_st            unit_task;
    logic                unit_miss;
    logic                unit_take;
    logic [CNT_W-1:0]    en_count;
    logic [BUDGET_W-1:0] cur_budget;
    logic [PERIOD_W-1:0] cur_period;
    logic                in_beat;
    logic                out_free;

    assign en_count   = (r_count > CNT_W'(NUM_TASKS)) ? CNT_W'(NUM_TASKS) : r_count;
    assign cur_budget = BUDGET_W'(r_budgets >> (BUDGET_W * r_idx));
    assign cur_period = PERIOD_W'(r_periods >> (PERIOD_W * r_idx));
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        unit_ctl.pass       = (r_state == S_SELECT) ? PASS_SELECT : PASS_UPDATE;
        unit_ctl.idx        = r_idx;
        unit_ctl.en_count   = en_count;
        unit_ctl.mode       = r_mode;
        unit_ctl.best_found = r_found;
    end

    pts_unit u_unit (
        .i_ctl     (unit_ctl),
        .i_task    (r_task[r_idx]),
        .i_budget  (cur_budget),
        .i_period  (cur_period),
        .i_now     (r_tick),
        .i_best_dl (r_best_dl),
        .o_task    (unit_task),
        .o_miss    (unit_miss),
        .o_take    (unit_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= POLICY_RM;
            r_count   <= 3'd3;
            r_budgets <= 32'h0001_0402;
            r_periods <= 64'h0000_0014_000A_0005;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLICY:  r_mode    <= t_policy'(i_cfg_data[0]);
                CFG_COUNT:   r_count   <= i_cfg_data[CNT_W-1:0];
                CFG_BUDGETS: r_budgets <= i_cfg_data[BUDGET_W*NUM_TASKS-1:0];
                CFG_PERIODS: r_periods <= i_cfg_data[PERIOD_W*NUM_TASKS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_best      <= '0;
            r_found     <= 1'b0;
            r_best_dl   <= '0;
            r_tick      <= '0;
            r_miss_cnt  <= '0;
            r_miss_mask <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_task[i] <= '0;
            end
        end else begin
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (i_restart) begin
                            r_tick     <= '0;
                            r_miss_cnt <= '0;
                            for (int i = 0; i < NUM_TASKS; i++) begin
                                r_task[i] <= '0;
                            end
                        end
                        r_idx       <= '0;
                        r_miss_mask <= '0;
                        r_state     <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_task[r_idx] <= unit_task;
                    if (unit_miss) begin
                        r_miss_mask[r_idx] <= 1'b1;
                        if (r_miss_cnt != '1) begin
                            r_miss_cnt <= r_miss_cnt + MISS_W'(1);
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_best_dl <= '0;
                        r_state   <= S_SELECT;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_SELECT: begin
                    if (unit_take) begin
                        r_found   <= 1'b1;
                        r_best    <= r_idx;
                        r_best_dl <= r_task[r_idx].deadline;
                    end
                    if (r_idx == LAST_IDX) begin
                        // Point the task index at the winner so the finish step
                        // charges its budget through the same read port.
                        r_idx   <= unit_take ? r_idx : r_best;
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (r_found) begin
                            r_task[r_idx].work <= r_task[r_idx].work - BUDGET_W'(1);
                        end
                        r_tick  <= r_tick + TICK_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_o_tick <= r_tick;
            r_o_task <= r_found ? r_idx : '0;
            r_o_idle <= !r_found;
            r_o_mask <= r_miss_mask;
            r_o_dl   <= r_found ? r_best_dl : '0;
            r_o_miss <= r_miss_cnt;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_tick_number     = r_o_tick;
    assign o_running_task    = r_o_task;
    assign o_cpu_idle        = r_o_idle;
    assign o_miss_mask       = r_o_mask;
    assign o_chosen_deadline = r_o_dl;
    assign o_miss_total      = r_o_miss;

`ifndef NO_ASSERTIONS
    a_accept_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_UPDATE) && (r_idx == '0) && (r_miss_mask == '0))
        else $error("accepted tick did not start the update pass at task zero");

    a_idle_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cpu_idle) |-> (o_running_task == '0) && (o_chosen_deadline == '0))
        else $error("idle result carries a task or deadline");

    a_finish_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_found) |-> (r_task[r_idx].work != '0))
        else $error("chosen task has no work left to charge");

    a_miss_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SELECT && $past(r_state == S_UPDATE)) |-> (r_miss_cnt >= $past(r_miss_cnt)))
        else $error("miss total went down during a tick");

    a_finish_waits_for_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && !i_out_ready) |=> (r_state == S_FINISH))
        else $error("result left the sequencer while the output register was full");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the periodic task tick scheduler top level.
module tb;
    import pts_pkg::*;

    localparam int TICK_LATENCY = 2 * NUM_TASKS + 2;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [TICK_W-1:0]    tick;
        logic [IDX_W-1:0]     run_idx;
        logic                 idle;
        logic [NUM_TASKS-1:0] miss_mask;
        logic [TICK_W-1:0]    deadline;
        logic [MISS_W-1:0]    total;
    } sched_report_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_restart   = 1'b0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [1:0]           i_cfg_index = CFG_POLICY;
    logic [63:0]          i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [TICK_W-1:0]    o_tick_number;
    logic [IDX_W-1:0]     o_running_task;
    logic                 o_cpu_idle;
    logic [NUM_TASKS-1:0] o_miss_mask;
    logic [TICK_W-1:0]    o_chosen_deadline;
    logic [MISS_W-1:0]    o_miss_total;

    // Scheduler model: configuration copy and per-task state.
    t_policy              cfg_policy;
    logic [CNT_W-1:0]     cfg_count;
    logic [31:0]          cfg_budgets;
    logic [63:0]          cfg_periods;
    logic [TICK_W-1:0]    mdl_tick;
    logic [BUDGET_W-1:0]  mdl_work [NUM_TASKS];
    logic [PERIOD_W-1:0]  mdl_phase [NUM_TASKS];
    logic [TICK_W-1:0]    mdl_deadline [NUM_TASKS];
    logic [MISS_W-1:0]    mdl_misses;

    sched_report_t pending_reports[$];

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int hold_left    = 0;
    int n_errors     = 0;
    int n_ticks      = 0;
    int n_reports    = 0;
    int n_miss_beats = 0;
    int n_idle_beats = 0;
    int n_settings   = 0;
    int stall_cycles = 0;

    periodic_task_tick_scheduler_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_tick_number     (o_tick_number),
        .o_running_task    (o_running_task),
        .o_cpu_idle        (o_cpu_idle),
        .o_miss_mask       (o_miss_mask),
        .o_chosen_deadline (o_chosen_deadline),
        .o_miss_total      (o_miss_total),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_sched_state();
        mdl_tick   = '0;
        mdl_misses = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            mdl_work[i]     = '0;
            mdl_phase[i]    = '0;
            mdl_deadline[i] = '0;
        end
    endfunction

    function automatic sched_report_t schedule_tick(input logic restart);
        sched_report_t       rep;
        int                  en_count;
        int                  best;
        logic [PERIOD_W-1:0] period;
        logic [BUDGET_W-1:0] budget;
        logic [PERIOD_W:0]   next_phase;
        logic [TICK_W-1:0]   best_dl;
        if (restart)
            clear_sched_state();
        rep      = '0;
        rep.tick = mdl_tick;
        en_count = (cfg_count > NUM_TASKS) ? NUM_TASKS : int'(cfg_count);
        for (int i = 0; i < NUM_TASKS; i++) begin
            period = cfg_periods[PERIOD_W*i +: PERIOD_W];
            budget = cfg_budgets[BUDGET_W*i +: BUDGET_W];
            if (i >= en_count || period == '0) begin
                mdl_work[i]  = '0;
                mdl_phase[i] = '0;
            end else begin
                if (mdl_phase[i] == '0) begin
                    // Work still pending at release is a missed deadline.
                    if (mdl_work[i] != '0) begin
                        rep.miss_mask[i] = 1'b1;
                        if (mdl_misses != '1)
                            mdl_misses++;
                    end
                    mdl_work[i]     = budget;
                    mdl_deadline[i] = mdl_tick + period;
                end
                next_phase   = mdl_phase[i] + 1'b1;
                mdl_phase[i] = (next_phase >= period) ? '0 : next_phase[PERIOD_W-1:0];
            end
        end
        best    = -1;
        best_dl = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (mdl_work[i] != '0 &&
                (best < 0 || (cfg_policy == POLICY_EDF && mdl_deadline[i] < best_dl))) begin
                best    = i;
                best_dl = mdl_deadline[i];
            end
        end
        if (best >= 0) begin
            mdl_work[best]--;
            rep.run_idx  = best[IDX_W-1:0];
            rep.deadline = best_dl;
        end else begin
            rep.idle = 1'b1;
        end
        rep.total = mdl_misses;
        mdl_tick++;
        return rep;
    endfunction

    // Sends one tick beat; returns at the edge where it was accepted.
    task automatic send_tick(input logic restart);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_reports.push_back(schedule_tick(restart));
        n_ticks++;
    endtask

    task automatic drain_ticks();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (TICK_LATENCY) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic write_config(input t_policy pol, input logic [CNT_W-1:0] cnt,
                                input logic [31:0] budgets, input logic [63:0] periods);
        drain_ticks();
        cfg_beat(CFG_POLICY, {63'd0, pol});
        cfg_beat(CFG_COUNT, {61'd0, cnt});
        cfg_beat(CFG_BUDGETS, {32'd0, budgets});
        cfg_beat(CFG_PERIODS, periods);
        i_cfg_we    <= 1'b0;
        cfg_policy  = pol;
        cfg_count   = cnt;
        cfg_budgets = budgets;
        cfg_periods = periods;
        n_settings++;
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        @(negedge i_clk);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        set_idling(0, 0);
        for (int k = 0; k < 6; k++)
            send_tick(k == 5);
    endtask

    task automatic test_special_cases();
        // Task 1 has period zero, task 2 has no budget, task 0 overruns its period,
        // and a count above the task total enables every task.
        write_config(POLICY_EDF, 3'd7, {8'hFF, 8'h00, 8'h05, 8'h03},
                     {16'hFFFF, 16'd3, 16'd0, 16'd2});
        for (int k = 0; k < 6; k++)
            send_tick(k == 0);
        // Shrinking the periods mid-run leaves phases past the new period.
        write_config(POLICY_EDF, 3'd4, {8'hFF, 8'h00, 8'h05, 8'h03},
                     {16'd2, 16'd4, 16'd3, 16'd2});
        for (int k = 0; k < 3; k++)
            send_tick(1'b0);
        write_config(POLICY_RM, 3'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int k = 0; k < 2; k++)
            send_tick(1'b0);
        // Every task released each tick with more work than fits: four misses on each tick after the first.
        write_config(POLICY_RM, 3'd4, 32'h0202_0202, 64'h0001_0001_0001_0001);
        for (int k = 0; k < 4; k++)
            send_tick(1'b0);
    endtask

    task automatic test_random_settings(input int in_pct, input int out_pct, input int n_items);
        int                 sent;
        int                 run_len;
        int                 pick;
        t_policy            pol;
        logic [CNT_W-1:0]   cnt;
        logic [31:0]        budgets;
        logic [63:0]        periods;
        set_idling(in_pct, out_pct);
        sent = 0;
        while (sent < n_items) begin
            pol = t_policy'($urandom_range(1));
            case ($urandom_range(9))
                0:       cnt = '0;
                1:       cnt = CNT_W'($urandom_range(7, 5));
                default: cnt = CNT_W'($urandom_range(4, 1));
            endcase
            for (int i = 0; i < NUM_TASKS; i++) begin
                pick = $urandom_range(15);
                budgets[8*i +: 8] = (pick == 0) ? 8'h00 :
                                    (pick == 1) ? 8'hFF :
                                    (pick == 2) ? 8'($urandom) : 8'($urandom_range(4, 1));
                pick = $urandom_range(15);
                periods[16*i +: 16] = (pick == 0) ? 16'h0000 :
                                      (pick == 1) ? 16'hFFFF :
                                      (pick == 2) ? 16'($urandom) : 16'($urandom_range(12, 1));
            end
            pick = $urandom_range(23);
            if (pick == 0) begin
                budgets = '1;
                periods = '1;
            end else if (pick == 1) begin
                budgets = '0;
                periods = '0;
            end else if (pick == 2) begin
                periods = {$urandom, $urandom};
                budgets = $urandom;
            end
            write_config(pol, cnt, budgets, periods);
            run_len = $urandom_range(90, 20);
            for (int k = 0; k < run_len; k++)
                send_tick((k == 0) ? 1'($urandom_range(1)) : ($urandom_range(39) == 0));
            sent += run_len;
        end
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        write_config(POLICY_EDF, 3'd4, 32'h0302_0101, 64'h0009_0007_0005_0003);
        @(negedge i_clk);
        hold_left = 400;
        @(posedge i_clk);
        for (int k = 0; k < 50; k++)
            send_tick(k == 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        sched_report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_reports++;
            if (o_miss_mask != '0)
                n_miss_beats++;
            if (o_cpu_idle)
                n_idle_beats++;
            if (pending_reports.size() == 0) begin
                $error("report beat with no tick pending, tick_number %0d", o_tick_number);
                n_errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("tick_number", want.tick, o_tick_number);
                check_field("running_task", 32'(want.run_idx), 32'(o_running_task));
                check_field("cpu_idle", 32'(want.idle), 32'(o_cpu_idle));
                check_field("miss_mask", 32'(want.miss_mask), 32'(o_miss_mask));
                check_field("chosen_deadline", want.deadline, o_chosen_deadline);
                check_field("miss_total", 32'(want.total), 32'(o_miss_total));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        cfg_policy  = POLICY_RM;
        cfg_count   = 3'd3;
        cfg_budgets = 32'h0001_0402;
        cfg_periods = 64'h0000_0014_000A_0005;
        clear_sched_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_cases();
        test_random_settings(23, 45, 450);
        test_random_settings(45, 23, 450);
        test_random_settings(0, 0, 450);
        test_output_backpressure();
        drain_ticks();
        repeat (TICK_LATENCY) @(posedge i_clk);

        if (pending_reports.size() != 0) begin
            $error("%0d ticks never produced a report", pending_reports.size());
            n_errors++;
        end
        $display("Ran %0d ticks (%0d reports) through %0d register settings in both policies,",
                 n_ticks, n_reports, n_settings);
        $display("with stalls on both channels; %0d reports had misses, %0d were idle.",
                 n_miss_beats, n_idle_beats);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pts_pkg.sv
rtl/pts_unit.sv
rtl/periodic_task_tick_scheduler_top.sv
test/tb.sv
